// File: rtl/lssc_pkg.sv
package lssc_pkg;

    localparam int RANGE_WIDTH = 16;
    localparam int ANGLE_START_WIDTH = 23;
    localparam int ANGLE_STEP_WIDTH = 19;
    localparam int ANGLE_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 23;

    typedef logic [RANGE_WIDTH-1:0] range_t;
    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MIN_RANGE   = 3'd0,
        CFG_MAX_RANGE   = 3'd1,
        CFG_ANGLE_START = 3'd2,
        CFG_ANGLE_STEP  = 3'd3,
        CFG_SAFETY      = 3'd4
    } cfg_index_t;

    localparam range_t MIN_RANGE_RESET = 16'd100;
    localparam range_t MAX_RANGE_RESET = 16'd12000;
    localparam logic signed [ANGLE_START_WIDTH-1:0] ANGLE_START_RESET = -23'sd3141593;
    localparam logic signed [ANGLE_STEP_WIDTH-1:0] ANGLE_STEP_RESET = 19'sd8727;
    localparam range_t SAFETY_RESET = 16'd1000;

    // Sector bounds in microradians.
    localparam angle_t SECTOR_INNER_POS = 32'sd500000;
    localparam angle_t SECTOR_INNER_NEG = -32'sd500000;
    localparam angle_t SECTOR_OUTER_POS = 32'sd1570000;
    localparam angle_t SECTOR_OUTER_NEG = -32'sd1570000;

endpackage

// File: rtl/lssc_if.sv
interface lssc_in_if;
    logic                       valid;
    logic                       ready;
    logic [lssc_pkg::RANGE_WIDTH-1:0] range_mm;
    logic                       last_sample;

    modport source (output valid, output range_mm, output last_sample, input ready);
    modport sink (input valid, input range_mm, input last_sample, output ready);
endinterface

interface lssc_out_if;
    logic                       valid;
    logic                       ready;
    logic [lssc_pkg::RANGE_WIDTH-1:0] left_clear_mm;
    logic [lssc_pkg::RANGE_WIDTH-1:0] right_clear_mm;
    logic [lssc_pkg::RANGE_WIDTH-1:0] front_clear_mm;
    logic                       obstacle;

    modport source (output valid, output left_clear_mm, output right_clear_mm,
                    output front_clear_mm, output obstacle, input ready);
    modport sink (input valid, input left_clear_mm, input right_clear_mm,
                  input front_clear_mm, input obstacle, output ready);
endinterface

interface lssc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [lssc_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [lssc_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/laser_scan_sector_clearance.sv
// Laser scan sector clearance: takes one range sample per cycle and keeps
// running minima of the left, right and front sectors by sample angle. The
// transaction carrying last_sample=1 closes the scan; its result (three
// clearances and the obstacle flag) is valid the next cycle and is held in
// a single output register. Sample input stays ready every cycle except
// while that register holds an untaken result and the sink is not ready.
// Configuration writes are always taken; write them between scans.
module laser_scan_sector_clearance
(
    input  logic              clk,
    input  logic              rst_n,
    lssc_cfg_if.sink          cfg,
    lssc_in_if.sink           sample,
    lssc_out_if.source        result
);

    lssc_pkg::range_t                                       min_range_reg;
    lssc_pkg::range_t                                       max_range_reg;
    logic signed [lssc_pkg::ANGLE_START_WIDTH-1:0]          angle_start_reg;
    logic signed [lssc_pkg::ANGLE_STEP_WIDTH-1:0]           angle_step_reg;
    lssc_pkg::range_t                                       safety_reg;

    lssc_pkg::angle_t angle_reg;
    lssc_pkg::angle_t angle_cur;
    lssc_pkg::angle_t angle_next;
    lssc_pkg::range_t left_min_reg;
    lssc_pkg::range_t right_min_reg;
    lssc_pkg::range_t front_min_reg;
    lssc_pkg::range_t left_cur;
    lssc_pkg::range_t right_cur;
    lssc_pkg::range_t front_cur;
    lssc_pkg::range_t left_min_next;
    lssc_pkg::range_t right_min_next;
    lssc_pkg::range_t front_min_next;
    logic             scan_start_reg;

    logic                             range_ok;
    logic                             in_left;
    logic                             in_right;
    logic                             in_front;
    logic                             take;
    logic [lssc_pkg::RANGE_WIDTH+2:0] safety_x3;
    logic [lssc_pkg::RANGE_WIDTH+2:0] left_x5;
    logic [lssc_pkg::RANGE_WIDTH+2:0] right_x5;
    logic                             obstacle_next;

    logic             out_valid_reg;
    lssc_pkg::range_t left_clear_reg;
    lssc_pkg::range_t right_clear_reg;
    lssc_pkg::range_t front_clear_reg;
    logic             obstacle_reg;

    assign cfg.ready    = 1'b1;
    assign sample.ready = !out_valid_reg || result.ready;
    assign take         = sample.valid && sample.ready;

    assign result.valid          = out_valid_reg;
    assign result.left_clear_mm  = left_clear_reg;
    assign result.right_clear_mm = right_clear_reg;
    assign result.front_clear_mm = front_clear_reg;
    assign result.obstacle       = obstacle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg   <= lssc_pkg::MIN_RANGE_RESET;
            max_range_reg   <= lssc_pkg::MAX_RANGE_RESET;
            angle_start_reg <= lssc_pkg::ANGLE_START_RESET;
            angle_step_reg  <= lssc_pkg::ANGLE_STEP_RESET;
            safety_reg      <= lssc_pkg::SAFETY_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (lssc_pkg::cfg_index_t'(cfg.index))
                lssc_pkg::CFG_MIN_RANGE:
                begin
                    min_range_reg <= cfg.data[lssc_pkg::RANGE_WIDTH-1:0];
                end
                lssc_pkg::CFG_MAX_RANGE:
                begin
                    max_range_reg <= cfg.data[lssc_pkg::RANGE_WIDTH-1:0];
                end
                lssc_pkg::CFG_ANGLE_START:
                begin
                    angle_start_reg <= cfg.data[lssc_pkg::ANGLE_START_WIDTH-1:0];
                end
                lssc_pkg::CFG_ANGLE_STEP:
                begin
                    angle_step_reg <= cfg.data[lssc_pkg::ANGLE_STEP_WIDTH-1:0];
                end
                lssc_pkg::CFG_SAFETY:
                begin
                    safety_reg <= cfg.data[lssc_pkg::RANGE_WIDTH-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // First sample of a scan starts from the configured angle and the maximum valid range.
    always_comb
    begin
        angle_cur = scan_start_reg
            ? {{(lssc_pkg::ANGLE_WIDTH-lssc_pkg::ANGLE_START_WIDTH){angle_start_reg[
                  lssc_pkg::ANGLE_START_WIDTH-1]}}, angle_start_reg}
            : angle_reg;
        left_cur  = scan_start_reg ? max_range_reg : left_min_reg;
        right_cur = scan_start_reg ? max_range_reg : right_min_reg;
        front_cur = scan_start_reg ? max_range_reg : front_min_reg;

        angle_next = angle_cur
            + {{(lssc_pkg::ANGLE_WIDTH-lssc_pkg::ANGLE_STEP_WIDTH){angle_step_reg[
                  lssc_pkg::ANGLE_STEP_WIDTH-1]}}, angle_step_reg};

        range_ok = (sample.range_mm >= min_range_reg) && (sample.range_mm <= max_range_reg);
        in_left  = (angle_cur < lssc_pkg::SECTOR_INNER_NEG)
                && (angle_cur > lssc_pkg::SECTOR_OUTER_NEG);
        in_right = (angle_cur > lssc_pkg::SECTOR_INNER_POS)
                && (angle_cur < lssc_pkg::SECTOR_OUTER_POS);
        in_front = (angle_cur >= lssc_pkg::SECTOR_INNER_NEG)
                && (angle_cur <= lssc_pkg::SECTOR_INNER_POS);

        left_min_next  = (range_ok && in_left && (sample.range_mm < left_cur))
                       ? sample.range_mm : left_cur;
        right_min_next = (range_ok && in_right && (sample.range_mm < right_cur))
                       ? sample.range_mm : right_cur;
        front_min_next = (range_ok && in_front && (sample.range_mm < front_cur))
                       ? sample.range_mm : front_cur;

        // side test: 5 * side < 3 * safety, exact
        safety_x3 = {3'b000, safety_reg} + {2'b00, safety_reg, 1'b0};
        left_x5   = {3'b000, left_min_next} + {1'b0, left_min_next, 2'b00};
        right_x5  = {3'b000, right_min_next} + {1'b0, right_min_next, 2'b00};
        obstacle_next = (front_min_next < safety_reg)
                     || (left_x5 < safety_x3)
                     || (right_x5 < safety_x3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_start_reg <= 1'b1;
        end
        else if (take)
        begin
            scan_start_reg <= sample.last_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            angle_reg     <= angle_next;
            left_min_reg  <= left_min_next;
            right_min_reg <= right_min_next;
            front_min_reg <= front_min_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && sample.last_sample)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && sample.last_sample)
        begin
            left_clear_reg  <= left_min_next;
            right_clear_reg <= right_min_next;
            front_clear_reg <= front_min_next;
            obstacle_reg    <= obstacle_next;
        end
    end

endmodule

// File: verif/laser_scan_sector_clearance_tb.sv
module laser_scan_sector_clearance_tb;

    localparam int LIMIT_CYCLES      = 1000000;
    localparam int DRAIN_CYCLES      = 4;
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int CFG_REG_COUNT     = 5;
    localparam int PHASE_ITEMS       = 135;
    localparam int RANGE_MASK        = (1 << lssc_pkg::RANGE_WIDTH) - 1;

    typedef logic [lssc_pkg::CFG_INDEX_WIDTH-1:0]          cfg_idx_t;
    typedef logic [lssc_pkg::CFG_DATA_WIDTH-1:0]           cfg_data_t;
    typedef logic signed [lssc_pkg::ANGLE_START_WIDTH-1:0] start_t;
    typedef logic signed [lssc_pkg::ANGLE_STEP_WIDTH-1:0]  step_t;

    class clearance_scoreboard;
        typedef struct packed {
            lssc_pkg::range_t left_mm;
            lssc_pkg::range_t right_mm;
            lssc_pkg::range_t front_mm;
            logic             obstacle;
        } clearance_t;

        lssc_pkg::range_t                      min_mm;
        lssc_pkg::range_t                      max_mm;
        start_t                                start_urad;
        step_t                                 step_urad;
        lssc_pkg::range_t                      safety_mm;
        lssc_pkg::angle_t                      angle;
        lssc_pkg::range_t                      left_min;
        lssc_pkg::range_t                      right_min;
        lssc_pkg::range_t                      front_min;
        bit                                    at_scan_start;
        clearance_t                            expected_clearances[$];
        int                                    errors;

        function new();
            min_mm        = lssc_pkg::MIN_RANGE_RESET;
            max_mm        = lssc_pkg::MAX_RANGE_RESET;
            start_urad    = lssc_pkg::ANGLE_START_RESET;
            step_urad     = lssc_pkg::ANGLE_STEP_RESET;
            safety_mm     = lssc_pkg::SAFETY_RESET;
            angle         = '0;
            left_min      = '0;
            right_min     = '0;
            front_min     = '0;
            at_scan_start = 1'b1;
            errors        = 0;
        endfunction

        function void apply_reg(cfg_idx_t idx, cfg_data_t value);
            case (idx)
                lssc_pkg::CFG_MIN_RANGE:   min_mm = value[lssc_pkg::RANGE_WIDTH-1:0];
                lssc_pkg::CFG_MAX_RANGE:   max_mm = value[lssc_pkg::RANGE_WIDTH-1:0];
                lssc_pkg::CFG_ANGLE_START: start_urad = value[lssc_pkg::ANGLE_START_WIDTH-1:0];
                lssc_pkg::CFG_ANGLE_STEP:  step_urad = value[lssc_pkg::ANGLE_STEP_WIDTH-1:0];
                lssc_pkg::CFG_SAFETY:      safety_mm = value[lssc_pkg::RANGE_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function void track_sample(lssc_pkg::range_t r, logic last);
            clearance_t c;
            if (at_scan_start)
            begin
                angle         = lssc_pkg::angle_t'(start_urad);
                left_min      = max_mm;
                right_min     = max_mm;
                front_min     = max_mm;
                at_scan_start = 1'b0;
            end
            if (r >= min_mm && r <= max_mm)
            begin
                if (angle < lssc_pkg::SECTOR_INNER_NEG && angle > lssc_pkg::SECTOR_OUTER_NEG)
                    left_min = (r < left_min) ? r : left_min;
                else if (angle > lssc_pkg::SECTOR_INNER_POS &&
                         angle < lssc_pkg::SECTOR_OUTER_POS)
                    right_min = (r < right_min) ? r : right_min;
                else if (angle >= lssc_pkg::SECTOR_INNER_NEG &&
                         angle <= lssc_pkg::SECTOR_INNER_POS)
                    front_min = (r < front_min) ? r : front_min;
            end
            angle = angle + lssc_pkg::angle_t'(step_urad);
            if (last)
            begin
                c.left_mm  = left_min;
                c.right_mm = right_min;
                c.front_mm = front_min;
                // sides trip at 0.6 of the safety distance, exact: 5*side < 3*safety
                c.obstacle = (front_min < safety_mm) ||
                             (5 * int'(left_min) < 3 * int'(safety_mm)) ||
                             (5 * int'(right_min) < 3 * int'(safety_mm));
                expected_clearances.push_back(c);
                at_scan_start = 1'b1;
            end
        endfunction

        function void compare_field(string name, int want, lssc_pkg::range_t got);
            if (got !== lssc_pkg::range_t'(want))
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(lssc_pkg::range_t l, lssc_pkg::range_t r,
                                   lssc_pkg::range_t f, logic obs);
            clearance_t want;
            if (expected_clearances.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d %0d %0d %0d",
                         $time, l, r, f, obs);
                errors++;
                return;
            end
            want = expected_clearances.pop_front();
            compare_field("left_clear_mm", int'(want.left_mm), l);
            compare_field("right_clear_mm", int'(want.right_mm), r);
            compare_field("front_clear_mm", int'(want.front_mm), f);
            compare_field("obstacle", int'(want.obstacle),
                          {{(lssc_pkg::RANGE_WIDTH-1){1'b0}}, obs});
        endfunction

        function int pending();
            return expected_clearances.size();
        endfunction

        function void check_drained();
            if (expected_clearances.size() != 0)
            begin
                $display("%0t: %0d results expected, actual none", $time,
                         expected_clearances.size());
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_off_req = 1'b0;

    clearance_scoreboard clr_sb;

    lssc_cfg_if cfg_bus ();
    lssc_in_if  sample_bus ();
    lssc_out_if result_bus ();

    laser_scan_sector_clearance u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus.sink),
        .sample (sample_bus.sink),
        .result (result_bus.source)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("laser_scan_sector_clearance test failed");
            $finish;
        end
    end

    // transaction monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                clr_sb.apply_reg(cfg_bus.index, cfg_bus.data);
            if (sample_bus.valid && sample_bus.ready)
                clr_sb.track_sample(sample_bus.range_mm, sample_bus.last_sample);
            if (result_bus.valid && result_bus.ready)
                clr_sb.check_result(result_bus.left_clear_mm, result_bus.right_clear_mm,
                                    result_bus.front_clear_mm, result_bus.obstacle);
        end
    end

    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(int r, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.range_mm    <= lssc_pkg::range_t'(r);
        sample_bus.last_sample <= last;
        do @(posedge clk); while (!sample_bus.ready);
    endtask

    task automatic wait_idle();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (clr_sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, int value);
        cfg_data_t word;
        word = cfg_data_t'($urandom);
        case (idx)
            lssc_pkg::CFG_ANGLE_START: word = cfg_data_t'(value);
            lssc_pkg::CFG_ANGLE_STEP:  word[lssc_pkg::ANGLE_STEP_WIDTH-1:0] = step_t'(value);
            lssc_pkg::CFG_MIN_RANGE, lssc_pkg::CFG_MAX_RANGE, lssc_pkg::CFG_SAFETY:
                word[lssc_pkg::RANGE_WIDTH-1:0] = lssc_pkg::range_t'(value);
            default: ;
        endcase
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= word;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    task automatic cfg_release();
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, int value);
        wait_idle();
        cfg_write(idx, value);
        cfg_release();
    endtask

    task automatic configure(int rmin, int rmax, int start, int step, int safety);
        wait_idle();
        cfg_write(lssc_pkg::CFG_MIN_RANGE, rmin);
        cfg_write(lssc_pkg::CFG_MAX_RANGE, rmax);
        cfg_write(lssc_pkg::CFG_ANGLE_START, start);
        cfg_write(lssc_pkg::CFG_ANGLE_STEP, step);
        cfg_write(lssc_pkg::CFG_SAFETY, safety);
        cfg_write(cfg_idx_t'($urandom_range((1 << lssc_pkg::CFG_INDEX_WIDTH) - 1,
                                            CFG_REG_COUNT)), $urandom);
        cfg_release();
    endtask

    function automatic int pick_range();
        int lo;
        int hi;
        int sel;
        int v;
        lo  = int'(clr_sb.min_mm);
        hi  = int'(clr_sb.max_mm);
        sel = $urandom_range(99);
        if (sel < 45 && lo <= hi)
            v = $urandom_range(hi, lo);
        else if (sel < 58)
            v = int'(clr_sb.safety_mm) + int'($urandom_range(6)) - 3;
        else if (sel < 70)
            v = (3 * int'(clr_sb.safety_mm)) / 5 + int'($urandom_range(4)) - 2;
        else if (sel < 80)
            v = ($urandom_range(1) ? lo : hi) + int'($urandom_range(2)) - 1;
        else if (sel < 88)
            v = $urandom_range(1) ? 0 : 65535;
        else
            v = $urandom_range(65535);
        return v & RANGE_MASK;
    endfunction

    task automatic run_scans(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
            for (int k = 0; k < len; k++)
                send_sample(pick_range(), k == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        int bound_angles[8];
        int start;
        int step;
        int lo;
        int hi;

        clr_sb = new();
        rst_n                  = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        sample_bus.valid       = 1'b0;
        sample_bus.range_mm    = '0;
        sample_bus.last_sample = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, single-sample scan below the window
        send_sample(50, 1'b1);

        configure(0, 65535, 0, 0, 1000);
        send_sample(0, 1'b1);
        send_sample(65535, 1'b1);

        configure(100, 12000, 0, 0, 1000);
        send_sample(99, 1'b1);
        send_sample(100, 1'b1);
        send_sample(12000, 1'b1);
        send_sample(12001, 1'b1);
        send_sample(999, 1'b1);
        send_sample(1000, 1'b1);

        bound_angles = '{lssc_pkg::SECTOR_OUTER_NEG, lssc_pkg::SECTOR_OUTER_NEG + 1,
                         lssc_pkg::SECTOR_INNER_NEG - 1, lssc_pkg::SECTOR_INNER_NEG,
                         lssc_pkg::SECTOR_INNER_POS, lssc_pkg::SECTOR_INNER_POS + 1,
                         lssc_pkg::SECTOR_OUTER_POS - 1, lssc_pkg::SECTOR_OUTER_POS};
        foreach (bound_angles[i])
        begin
            set_reg(lssc_pkg::CFG_ANGLE_START, bound_angles[i]);
            send_sample(700, 1'b1);
        end

        set_reg(lssc_pkg::CFG_ANGLE_START, -1000000);
        send_sample(599, 1'b1);
        send_sample(600, 1'b1);
        set_reg(lssc_pkg::CFG_ANGLE_START, 1000000);
        send_sample(599, 1'b1);

        // empty window
        configure(5000, 4000, 0, 0, 1000);
        send_sample(4500, 1'b0);
        send_sample(4500, 1'b1);

        // register writes in the middle of a scan
        configure(100, 12000, -1000000, 0, 1000);
        send_sample(3000, 1'b0);
        wait_idle();
        cfg_write(lssc_pkg::CFG_MAX_RANGE, 2500);
        cfg_write(lssc_pkg::CFG_MIN_RANGE, 0);
        cfg_write(lssc_pkg::CFG_ANGLE_STEP, 200000);
        cfg_write(lssc_pkg::CFG_ANGLE_START, 0);
        cfg_release();
        send_sample(2400, 1'b0);
        send_sample(2450, 1'b1);
        send_sample(2000, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    start = -int'($urandom_range(2200000, 300000));
                    configure($urandom_range(500), $urandom_range(65535, 5000), start,
                              $urandom_range(200000, 40000), $urandom_range(3000, 200));
                end
                1:
                begin
                    start = $urandom_range(2200000, 300000);
                    configure($urandom_range(500), $urandom_range(20000, 3000), start,
                              -int'($urandom_range(200000, 40000)),
                              $urandom_range(5000, 500));
                end
                2: configure(0, 65535, -3141593, 200000, 65535);
                3: configure(65535, 65535, 3141593, -200000, 0);
                4:
                begin
                    start = int'($urandom_range(6283186)) - 3141593;
                    step  = int'($urandom_range(400000)) - 200000;
                    configure($urandom_range(65535), $urandom_range(65535), start, step,
                              $urandom_range(65535));
                end
                default:
                begin
                    lo    = $urandom_range(4000, 100);
                    hi    = lo + int'($urandom_range(2000));
                    start = -int'($urandom_range(1800000, 600000));
                    step  = $urandom_range(200000, 20000);
                    configure(lo, hi, start, step, $urandom_range(hi + 200, lo));
                end
            endcase
            send_idle_pct = (p < 2) ? 27 : (p < 4) ? 56 : 0;
            recv_idle_pct = (p < 2) ? 56 : (p < 4) ? 27 : 0;
            if (p == 0)
                hold_off_req = 1'b1;
            run_scans(PHASE_ITEMS);
        end

        wait_idle();
        clr_sb.check_drained();
        if (clr_sb.errors == 0)
            $display("laser_scan_sector_clearance test passed");
        else
            $display("laser_scan_sector_clearance test failed");
        $finish;
    end

endmodule

// File: laser_scan_sector_clearance.f
rtl/lssc_pkg.sv
rtl/lssc_if.sv
rtl/laser_scan_sector_clearance.sv
verif/laser_scan_sector_clearance_tb.sv
